[rtl/xat_pkg.sv]
`default_nettype none

package xat_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int TOKEN_SLOTS = 256;

    localparam int STR_W  = 13;
    localparam int TOK_W  = 9;
    localparam int CONS_W = 16;
    localparam int CFG_W  = STR_W;

    localparam logic [STR_W-1:0] STR_CAP_RESET =
        (STORE_BYTES > 8191) ? STR_W'(8191) : STR_W'(STORE_BYTES);
    localparam logic [TOK_W-1:0] TOK_CAP_RESET =
        (TOKEN_SLOTS > 511) ? TOK_W'(511) : TOK_W'(TOKEN_SLOTS);

    localparam logic [STR_W-1:0]  TCB_MAX  = '1;
    localparam logic [CONS_W-1:0] CONS_MAX = '1;

    // configuration register indexes
    localparam logic CFG_STRING_CAPACITY = 1'b0;
    localparam logic CFG_TOKEN_CAPACITY  = 1'b1;

    // event codes
    localparam logic [3:0] EV_SKIP        = 4'd0;
    localparam logic [3:0] EV_NAME_BYTE   = 4'd1;
    localparam logic [3:0] EV_VALUE_BYTE  = 4'd2;
    localparam logic [3:0] EV_NAME_DONE   = 4'd3;
    localparam logic [3:0] EV_VALUE_DONE  = 4'd4;
    localparam logic [3:0] EV_LIST_END    = 4'd5;
    localparam logic [3:0] EV_NO_EQUAL    = 4'd6;
    localparam logic [3:0] EV_NO_OPEN_Q   = 4'd7;
    localparam logic [3:0] EV_NO_CLOSE_Q  = 4'd8;
    localparam logic [3:0] EV_STRING_FULL = 4'd9;
    localparam logic [3:0] EV_TOKEN_FULL  = 4'd10;
    localparam logic [3:0] EV_IDLE        = 4'd11;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_ASCII_MAX = 8'h7f;

    typedef enum logic [5:0] {
        PH_IDLE        = 6'b000001,
        PH_BEFORE_NAME = 6'b000010,
        PH_IN_NAME     = 6'b000100,
        PH_AFTER_NAME  = 6'b001000,
        PH_AFTER_EQ    = 6'b010000,
        PH_IN_VALUE    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       start_list;
        logic       clear_store;
    } text_word_t;

    typedef struct packed {
        logic [3:0]        event_res;
        logic [7:0]        echo_byte;
        logic [STR_W-1:0]  token_length;
        logic [CONS_W-1:0] consumed_length;
    } event_word_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_name_start(input logic [7:0] c);
        return (c == CH_COLON) || (c == CH_UNDER) || (c >= 8'h61 && c <= 8'h7a)
            || (c >= 8'h41 && c <= 8'h5a) || (c > CH_ASCII_MAX);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return is_name_start(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_DOT)
            || (c == CH_DASH);
    endfunction

endpackage

`default_nettype wire

[rtl/xml_attribute_tokenizer_unit.sv]
// channel | valid      | stall      | payload
// text    | text_valid | text_stall | text_word  (byte, start_list, clear_store)
// event   | event_valid| event_stall| event_word (event, echo, length, consumed)
//
// one word in, one word out via input and result registers, one per cycle unless stalled
// the lexer state is updated as a word leaves the input register for the result register
// event_stall backs up through the result register into text_stall in the same cycle
// rst_n clears the lexer state, the usage counters and both valid flags, and loads
// the capacity registers with their full-store values
`default_nettype none

module xml_attribute_tokenizer_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        text_valid,
    output      logic                        text_stall,
    input  wire xat_pkg::text_word_t         text_word,
    output      logic                        event_valid,
    input  wire logic                        event_stall,
    output      xat_pkg::event_word_t        event_word,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [xat_pkg::CFG_W-1:0]   cfg_data
);

    logic                          in_valid_reg;
    xat_pkg::text_word_t           in_word_reg;
    logic                          out_valid_reg;
    xat_pkg::event_word_t          out_word_reg;
    xat_pkg::event_word_t          out_word_next;

    logic [xat_pkg::STR_W-1:0]     str_cap_reg;
    logic [xat_pkg::TOK_W-1:0]     tok_cap_reg;

    xat_pkg::phase_t               phase_reg, phase_next;
    logic                          quote_single_reg, quote_single_next;
    logic [xat_pkg::STR_W-1:0]     tcb_reg, tcb_next;
    logic [xat_pkg::CONS_W-1:0]    consumed_reg, consumed_next;
    logic [xat_pkg::STR_W-1:0]     str_used_reg, str_used_next;
    logic [xat_pkg::TOK_W-1:0]     tok_used_reg, tok_used_next;

    logic                          advance;
    logic                          out_free;

    // working values after clear_store and start_list
    xat_pkg::phase_t               ph_eff;
    logic [xat_pkg::STR_W-1:0]     tcb_eff;
    logic [xat_pkg::STR_W-1:0]     tcb_inc;
    logic [xat_pkg::CONS_W-1:0]    cons_eff;
    logic [xat_pkg::STR_W-1:0]     su_eff;
    logic [xat_pkg::TOK_W-1:0]     tu_eff;
    logic [xat_pkg::STR_W+1:0]     str_sum;
    logic [xat_pkg::TOK_W:0]       tok_sum;
    logic                          str_fit;
    logic                          tok_fit;
    logic                          count;
    logic [7:0]                    c;
    logic [7:0]                    close_q;
    logic                          commit_ok;
    logic [3:0]                    commit_err;
    logic [3:0]                    ev;
    logic [7:0]                    echo;
    logic [xat_pkg::STR_W-1:0]     tlen;

    assign out_free    = !out_valid_reg || !event_stall;
    assign advance     = in_valid_reg && out_free;
    assign text_stall  = in_valid_reg && !out_free;
    assign event_valid = out_valid_reg;
    assign event_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!text_stall)
        begin
            in_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && !text_stall)
        begin
            in_word_reg <= text_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            str_cap_reg <= xat_pkg::STR_CAP_RESET;
            tok_cap_reg <= xat_pkg::TOK_CAP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                xat_pkg::CFG_STRING_CAPACITY: str_cap_reg <= cfg_data;
                xat_pkg::CFG_TOKEN_CAPACITY:  tok_cap_reg <= cfg_data[xat_pkg::TOK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= xat_pkg::PH_IDLE;
            quote_single_reg <= 1'b0;
            tcb_reg          <= '0;
            consumed_reg     <= '0;
            str_used_reg     <= '0;
            tok_used_reg     <= '0;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            quote_single_reg <= quote_single_next;
            tcb_reg          <= tcb_next;
            consumed_reg     <= consumed_next;
            str_used_reg     <= str_used_next;
            tok_used_reg     <= tok_used_next;
        end
    end

    always_comb
    begin
        c        = in_word_reg.text_byte;
        su_eff   = in_word_reg.clear_store ? '0 : str_used_reg;
        tu_eff   = in_word_reg.clear_store ? '0 : tok_used_reg;
        ph_eff   = in_word_reg.start_list ? xat_pkg::PH_BEFORE_NAME : phase_reg;
        tcb_eff  = in_word_reg.start_list ? '0 : tcb_reg;
        cons_eff = in_word_reg.start_list ? '0 : consumed_reg;
        tcb_inc  = (tcb_eff != xat_pkg::TCB_MAX) ? tcb_eff + 1'b1 : tcb_eff;
        close_q  = quote_single_reg ? xat_pkg::CH_SQ : xat_pkg::CH_DQ;

        // string store takes the token plus one terminator
        str_sum    = {2'b00, su_eff} + {2'b00, tcb_eff} + 15'd1;
        tok_sum    = {1'b0, tu_eff} + 10'd1;
        str_fit    = str_sum <= {2'b00, str_cap_reg};
        tok_fit    = tok_sum <= {1'b0, tok_cap_reg};
        commit_ok  = str_fit && tok_fit;
        commit_err = !str_fit ? xat_pkg::EV_STRING_FULL : xat_pkg::EV_TOKEN_FULL;

        phase_next        = ph_eff;
        quote_single_next = quote_single_reg;
        tcb_next          = tcb_eff;
        str_used_next     = su_eff;
        tok_used_next     = tu_eff;
        count             = 1'b1;
        ev                = xat_pkg::EV_SKIP;
        echo              = '0;
        tlen              = '0;

        case (ph_eff)
            xat_pkg::PH_IDLE:
            begin
                ev    = xat_pkg::EV_IDLE;
                count = 1'b0;
            end
            xat_pkg::PH_BEFORE_NAME:
            begin
                if (xat_pkg::is_space(c))
                begin
                    ev = xat_pkg::EV_SKIP;
                end
                else if (xat_pkg::is_name_start(c))
                begin
                    ev         = xat_pkg::EV_NAME_BYTE;
                    echo       = c;
                    tcb_next   = xat_pkg::STR_W'(1);
                    phase_next = xat_pkg::PH_IN_NAME;
                end
                else
                begin
                    ev         = xat_pkg::EV_LIST_END;
                    phase_next = xat_pkg::PH_IDLE;
                    count      = 1'b0;
                end
            end
            xat_pkg::PH_IN_NAME:
            begin
                if (xat_pkg::is_name_char(c))
                begin
                    ev       = xat_pkg::EV_NAME_BYTE;
                    echo     = c;
                    tcb_next = tcb_inc;
                end
                else if (!xat_pkg::is_space(c) && c != xat_pkg::CH_EQ)
                begin
                    ev         = xat_pkg::EV_NO_EQUAL;
                    phase_next = xat_pkg::PH_IDLE;
                end
                else if (!commit_ok)
                begin
                    ev         = commit_err;
                    phase_next = xat_pkg::PH_IDLE;
                end
                else
                begin
                    ev            = xat_pkg::EV_NAME_DONE;
                    tlen          = tcb_eff;
                    str_used_next = str_sum[xat_pkg::STR_W-1:0];
                    tok_used_next = tok_sum[xat_pkg::TOK_W-1:0];
                    phase_next    = (c == xat_pkg::CH_EQ) ? xat_pkg::PH_AFTER_EQ
                                                          : xat_pkg::PH_AFTER_NAME;
                end
            end
            xat_pkg::PH_AFTER_NAME:
            begin
                if (xat_pkg::is_space(c))
                begin
                    ev = xat_pkg::EV_SKIP;
                end
                else if (c == xat_pkg::CH_EQ)
                begin
                    ev         = xat_pkg::EV_SKIP;
                    phase_next = xat_pkg::PH_AFTER_EQ;
                end
                else
                begin
                    ev         = xat_pkg::EV_NO_EQUAL;
                    phase_next = xat_pkg::PH_IDLE;
                end
            end
            xat_pkg::PH_AFTER_EQ:
            begin
                if (xat_pkg::is_space(c))
                begin
                    ev = xat_pkg::EV_SKIP;
                end
                else if (c == xat_pkg::CH_DQ || c == xat_pkg::CH_SQ)
                begin
                    ev                = xat_pkg::EV_SKIP;
                    quote_single_next = (c == xat_pkg::CH_SQ);
                    tcb_next          = '0;
                    phase_next        = xat_pkg::PH_IN_VALUE;
                end
                else
                begin
                    ev         = xat_pkg::EV_NO_OPEN_Q;
                    phase_next = xat_pkg::PH_IDLE;
                end
            end
            xat_pkg::PH_IN_VALUE:
            begin
                if (c == close_q)
                begin
                    if (!commit_ok)
                    begin
                        ev         = commit_err;
                        phase_next = xat_pkg::PH_IDLE;
                    end
                    else
                    begin
                        ev            = xat_pkg::EV_VALUE_DONE;
                        tlen          = tcb_eff;
                        str_used_next = str_sum[xat_pkg::STR_W-1:0];
                        tok_used_next = tok_sum[xat_pkg::TOK_W-1:0];
                        phase_next    = xat_pkg::PH_BEFORE_NAME;
                    end
                end
                else if (c == xat_pkg::CH_NUL)
                begin
                    ev         = xat_pkg::EV_NO_CLOSE_Q;
                    phase_next = xat_pkg::PH_IDLE;
                end
                else
                begin
                    ev       = xat_pkg::EV_VALUE_BYTE;
                    echo     = c;
                    tcb_next = tcb_inc;
                end
            end
            default:
            begin
                ev         = xat_pkg::EV_IDLE;
                count      = 1'b0;
                phase_next = xat_pkg::PH_IDLE;
            end
        endcase

        // idle bytes leave everything but the clear and start effects alone
        if (ph_eff == xat_pkg::PH_IDLE)
        begin
            tcb_next = tcb_eff;
        end

        consumed_next = (count && cons_eff != xat_pkg::CONS_MAX) ? cons_eff + 1'b1
                                                                  : cons_eff;

        out_word_next.event_res       = ev;
        out_word_next.echo_byte       = echo;
        out_word_next.token_length    = tlen;
        out_word_next.consumed_length = consumed_next;
    end

endmodule

`default_nettype wire

[rtl/xat_checker.sv]
`default_nettype none

module xat_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 event_valid,
    input wire logic                 event_stall,
    input wire xat_pkg::event_word_t event_word
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_stall |=> event_valid && $stable(event_word))
        else $error("event word changed while stalled");

    a_echo_only_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_word.event_res != xat_pkg::EV_NAME_BYTE
        && event_word.event_res != xat_pkg::EV_VALUE_BYTE |-> event_word.echo_byte == 8'd0)
        else $error("echo byte set on a non-byte event");

    a_length_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && event_word.event_res != xat_pkg::EV_NAME_DONE
        && event_word.event_res != xat_pkg::EV_VALUE_DONE
        |-> event_word.token_length == '0)
        else $error("token length set on an event that commits nothing");

    a_byte_event_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        event_valid && (event_word.event_res == xat_pkg::EV_NAME_BYTE
        || event_word.event_res == xat_pkg::EV_VALUE_BYTE)
        |-> event_word.echo_byte != 8'd0 && event_word.consumed_length != '0)
        else $error("byte event with empty echo or no consumed count");

endmodule

bind xml_attribute_tokenizer_unit xat_checker u_xat_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .event_valid (event_valid),
    .event_stall (event_stall),
    .event_word  (event_word)
);

`default_nettype wire

[bench/xat_event_checker.sv]
`timescale 1ns / 1ps

module xat_event_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      text_valid,
    input  wire logic                      text_stall,
    input  wire xat_pkg::text_word_t       text_word,
    input  wire logic                      event_valid,
    input  wire logic                      event_stall,
    input  wire xat_pkg::event_word_t      event_word,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [xat_pkg::CFG_W-1:0] cfg_data,
    output int                             errors,
    output int                             awaiting
);
    import xat_pkg::*;

    phase_t            lex_phase;
    logic              single_quoted;
    logic [STR_W-1:0]  tok_bytes;
    logic [CONS_W-1:0] list_count;
    logic [STR_W-1:0]  str_used;
    logic [TOK_W-1:0]  toks_used;
    logic [STR_W-1:0]  str_cap;
    logic [TOK_W-1:0]  tok_cap;

    event_word_t pending_events[$];
    event_word_t want;

    function automatic logic blank_byte(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic opens_name(input logic [7:0] c);
        return c == CH_COLON || c == CH_UNDER || c > CH_ASCII_MAX
            || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic continues_name(input logic [7:0] c);
        return opens_name(c) || (c >= "0" && c <= "9") || c == CH_DOT || c == CH_DASH;
    endfunction

    // reserves room for the current token; string room is checked before the slot
    function automatic logic claim_store(output logic [3:0] full_ev);
        full_ev = EV_SKIP;
        if ({1'b0, str_used} + {1'b0, tok_bytes} + 14'd1 > {1'b0, str_cap})
            full_ev = EV_STRING_FULL;
        else if ({1'b0, toks_used} + 10'd1 > {1'b0, tok_cap})
            full_ev = EV_TOKEN_FULL;
        else
        begin
            str_used  = str_used + tok_bytes + 1'b1;
            toks_used = toks_used + 1'b1;
        end
        return full_ev == EV_SKIP;
    endfunction

    function automatic event_word_t lex_byte(input text_word_t w);
        event_word_t r;
        logic [7:0]  c;
        logic        counted;
        logic [3:0]  full_ev;
        c = w.text_byte;
        r = '0;
        counted = 1'b1;
        if (w.clear_store)
        begin
            str_used  = '0;
            toks_used = '0;
        end
        if (w.start_list)
        begin
            lex_phase  = PH_BEFORE_NAME;
            list_count = '0;
            tok_bytes  = '0;
        end
        if (lex_phase == PH_IDLE)
            r.event_res = EV_IDLE;
        else
        begin
            r.event_res = EV_SKIP;
            case (lex_phase)
                PH_BEFORE_NAME:
                    if (blank_byte(c))
                        r.event_res = EV_SKIP;
                    else if (opens_name(c))
                    begin
                        r.event_res = EV_NAME_BYTE;
                        r.echo_byte = c;
                        tok_bytes   = STR_W'(1);
                        lex_phase   = PH_IN_NAME;
                    end
                    else
                    begin
                        // the terminating byte is not part of the list
                        r.event_res = EV_LIST_END;
                        lex_phase   = PH_IDLE;
                        counted     = 1'b0;
                    end
                PH_IN_NAME:
                    if (continues_name(c))
                    begin
                        r.event_res = EV_NAME_BYTE;
                        r.echo_byte = c;
                        if (tok_bytes != TCB_MAX)
                            tok_bytes = tok_bytes + 1'b1;
                    end
                    else if (!blank_byte(c) && c != CH_EQ)
                    begin
                        r.event_res = EV_NO_EQUAL;
                        lex_phase   = PH_IDLE;
                    end
                    else if (!claim_store(full_ev))
                    begin
                        r.event_res = full_ev;
                        lex_phase   = PH_IDLE;
                    end
                    else
                    begin
                        r.event_res    = EV_NAME_DONE;
                        r.token_length = tok_bytes;
                        lex_phase      = (c == CH_EQ) ? PH_AFTER_EQ : PH_AFTER_NAME;
                    end
                PH_AFTER_NAME:
                    if (c == CH_EQ)
                        lex_phase = PH_AFTER_EQ;
                    else if (!blank_byte(c))
                    begin
                        r.event_res = EV_NO_EQUAL;
                        lex_phase   = PH_IDLE;
                    end
                PH_AFTER_EQ:
                    if (c == CH_DQ || c == CH_SQ)
                    begin
                        single_quoted = (c == CH_SQ);
                        tok_bytes     = '0;
                        lex_phase     = PH_IN_VALUE;
                    end
                    else if (!blank_byte(c))
                    begin
                        r.event_res = EV_NO_OPEN_Q;
                        lex_phase   = PH_IDLE;
                    end
                default:
                    if (c == (single_quoted ? CH_SQ : CH_DQ))
                    begin
                        if (!claim_store(full_ev))
                        begin
                            r.event_res = full_ev;
                            lex_phase   = PH_IDLE;
                        end
                        else
                        begin
                            r.event_res    = EV_VALUE_DONE;
                            r.token_length = tok_bytes;
                            lex_phase      = PH_BEFORE_NAME;
                        end
                    end
                    else if (c == CH_NUL)
                    begin
                        r.event_res = EV_NO_CLOSE_Q;
                        lex_phase   = PH_IDLE;
                    end
                    else
                    begin
                        r.event_res = EV_VALUE_BYTE;
                        r.echo_byte = c;
                        if (tok_bytes != TCB_MAX)
                            tok_bytes = tok_bytes + 1'b1;
                    end
            endcase
            if (counted && list_count != CONS_MAX)
                list_count = list_count + 1'b1;
        end
        r.consumed_length = list_count;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] exp,
                               input logic [15:0] got);
        if (got !== exp)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, what, exp, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_phase     = PH_IDLE;
            single_quoted = 1'b0;
            tok_bytes     = '0;
            list_count    = '0;
            str_used      = '0;
            toks_used     = '0;
            str_cap       = STR_CAP_RESET;
            tok_cap       = TOK_CAP_RESET;
            errors        = 0;
            pending_events.delete();
            awaiting <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_STRING_CAPACITY)
                    str_cap = cfg_data;
                else
                    tok_cap = cfg_data[TOK_W-1:0];
            end
            if (event_valid && !event_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    errors++;
                    $display("%0t: event word %h arrived with none expected",
                             $time, event_word);
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("event_res", want.event_res, event_word.event_res);
                    check_field("echo_byte", want.echo_byte, event_word.echo_byte);
                    check_field("token_length", want.token_length,
                                event_word.token_length);
                    check_field("consumed_length", want.consumed_length,
                                event_word.consumed_length);
                end
            end
            if (text_valid && !text_stall)
                pending_events.push_back(lex_byte(text_word));
            awaiting <= pending_events.size();
        end
    end

endmodule

[bench/tb_xml_attribute_tokenizer_unit.sv]
`timescale 1ns / 1ps

module tb_xml_attribute_tokenizer_unit;
    import xat_pkg::*;

    localparam int CYCLE_LIMIT    = 500000;
    localparam int WORDS_PER_STEP = 75;

    logic             clk;
    logic             rst_n;
    logic             text_valid;
    logic             text_stall;
    text_word_t       text_word;
    logic             event_valid;
    logic             event_stall = 1'b0;
    event_word_t      event_word;
    logic             cfg_we;
    logic             cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int mismatches;
    int awaiting;
    int cycles     = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int words_sent = 0;

    xml_attribute_tokenizer_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_word   (text_word),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_word  (event_word),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    xat_event_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_stall  (text_stall),
        .text_word   (text_word),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_word  (event_word),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (mismatches),
        .awaiting    (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        event_stall <= rst_n && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_xml_attribute_tokenizer_unit NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(3))
            0: return CH_SP;
            1: return CH_TAB;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_lead();
        case ($urandom_range(5))
            0: return CH_COLON;
            1: return CH_UNDER;
            2: return 8'h61 + 8'($urandom_range(25));
            3: return 8'h41 + 8'($urandom_range(25));
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_tail();
        case ($urandom_range(4))
            0: return 8'h30 + 8'($urandom_range(9));
            1: return CH_DOT;
            2: return CH_DASH;
            default: return pick_lead();
        endcase
    endfunction

    function automatic logic [7:0] pick_value(input logic [7:0] quote);
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == quote);
        return b;
    endfunction

    // bytes that close a list where a name could begin
    function automatic logic [7:0] pick_stop();
        case ($urandom_range(4))
            0: return CH_NUL;
            1: return 8'h2f;
            2: return 8'h3e;
            3: return CH_EQ;
            default: return 8'h30 + 8'($urandom_range(9));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic start, input logic clear);
        while ($urandom_range(99) < idle_pct)
        begin
            text_valid <= 1'b0;
            @(posedge clk);
        end
        text_valid <= 1'b1;
        text_word  <= '{text_byte: b, start_list: start, clear_store: clear};
        do
            @(posedge clk);
        while (text_stall);
    endtask

    // let every outstanding word drain so the block is idle
    task automatic settle();
        text_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaiting != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] str_cap,
                             input logic [CFG_W-1:0] tok_cap);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_STRING_CAPACITY;
        cfg_data  <= str_cap;
        @(posedge clk);
        cfg_index <= CFG_TOKEN_CAPACITY;
        cfg_data  <= tok_cap;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed name="value" lists, with a corrupted byte or a restart now and then
    task automatic send_list();
        logic [7:0] text[$];
        logic [7:0] quote;
        int         value_len;
        int         restart_at;
        logic       first;
        repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
        repeat ($urandom_range(0, 4))
        begin
            text.push_back(pick_lead());
            repeat ($urandom_range(0, 5)) text.push_back(pick_tail());
            repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
            text.push_back(CH_EQ);
            repeat ($urandom_range(0, 2)) text.push_back(pick_blank());
            quote = $urandom_range(1) ? CH_SQ : CH_DQ;
            text.push_back(quote);
            value_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
            repeat (value_len) text.push_back(pick_value(quote));
            text.push_back(quote);
            repeat ($urandom_range(0, 1)) text.push_back(pick_blank());
        end
        text.push_back(pick_stop());
        if ($urandom_range(5) == 0)
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
        restart_at = ($urandom_range(9) == 0) ? $urandom_range(1, text.size()) : 0;
        foreach (text[i])
        begin
            first = (i == 0 || i == restart_at);
            send_byte(text[i], first, first && $urandom_range(4) == 0);
        end
        words_sent += text.size();
        // stray bytes after the list should just read as idle
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    endtask

    initial
    begin
        logic [7:0] intro[21] = '{CH_SP, CH_COLON, CH_UNDER, 8'hff, "Z", "9", CH_DOT,
                                  CH_DASH, CH_TAB, CH_EQ, CH_SP, CH_DQ, 8'h80, CH_SQ,
                                  CH_DQ, CH_CR, "b", CH_EQ, CH_SQ, CH_SQ, CH_NUL};
        int q;
        rst_n      = 1'b0;
        text_valid = 1'b0;
        text_word  = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_STRING_CAPACITY;
        cfg_data   = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no list open yet
        send_byte("A", 1'b0, 1'b0);
        foreach (intro[i])
            send_byte(intro[i], i == 0, i == 0);
        // name cut by a stray byte
        send_byte("a", 1'b1, 1'b0);
        send_byte("!", 1'b0, 1'b0);
        // value without an opening quote
        send_byte("q", 1'b1, 1'b0);
        send_byte(CH_EQ, 1'b0, 1'b0);
        send_byte("x", 1'b0, 1'b0);
        // text ends inside a value
        send_byte("n", 1'b1, 1'b0);
        send_byte(CH_EQ, 1'b0, 1'b0);
        send_byte(CH_DQ, 1'b0, 1'b0);
        send_byte(CH_NUL, 1'b0, 1'b0);

        for (int seg = 0; seg < 12; seg++)
        begin
            settle();
            case (seg % 3)
                0: configure(STR_CAP_RESET, CFG_W'(TOK_CAP_RESET));
                1: configure(CFG_W'($urandom_range(80)), CFG_W'($urandom_range(8)));
                default:
                    if (seg == 2)
                        configure('0, '0);
                    else
                        configure(CFG_W'($urandom_range(4096)), CFG_W'($urandom_range(256)));
            endcase
            q = seg / 3;
            idle_pct  = (q == 1) ? 57 : (q == 3) ? 29 : 0;
            stall_pct = (q == 2) ? 57 : (q == 3) ? 29 : 0;
            words_sent = 0;
            while (words_sent < WORDS_PER_STEP)
                send_list();
        end

        settle();
        if (mismatches == 0 && awaiting == 0)
            $display("tb_xml_attribute_tokenizer_unit OK");
        else
            $display("tb_xml_attribute_tokenizer_unit NOT OK");
        $finish;
    end

endmodule

[sim.f]
rtl/xat_pkg.sv
rtl/xml_attribute_tokenizer_unit.sv
rtl/xat_checker.sv
bench/xat_event_checker.sv
bench/tb_xml_attribute_tokenizer_unit.sv
